FILE: sv/uee_pkg.sv
// shared types and constants for the unique edge extractor
package uee_pkg;

    localparam int VERTEX_W   = 16;
    localparam int EDGE_NUM_W = 10;
    localparam int TOTAL_W    = 11;
    localparam int LANES      = 3;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_c;
        logic                first_triangle;
    } t_item;

    typedef struct packed {
        logic [VERTEX_W-1:0]   edge_from;
        logic [VERTEX_W-1:0]   edge_to;
        logic [EDGE_NUM_W-1:0] edge_number;
        logic [TOTAL_W-1:0]    total_edges;
        logic                  dropped;
        logic                  last_of_triangle;
    } t_result;

    typedef struct packed {
        logic [LANES-1:0] is_new;
        logic [LANES-1:0] is_last;
    } t_merge;

endpackage

FILE: sv/uee_lane.sv
// one compare lane: matches its edge against the table entries streamed past it
module uee_lane import uee_pkg::*; #(
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_en,
    input  logic [VW-1:0] i_from,
    input  logic [VW-1:0] i_to,
    input  logic [2*VW-1:0] i_entry,
    output logic          o_found
);

    logic          r_found;
    logic          n_found;
    logic [VW-1:0] ent_from;
    logic [VW-1:0] ent_to;
    logic          match;

    assign ent_from = i_entry[2*VW-1:VW];
    assign ent_to   = i_entry[VW-1:0];
    assign match    = ((i_from == ent_from) && (i_to == ent_to)) ||
                      ((i_from == ent_to) && (i_to == ent_from));

    always_comb begin
        n_found = r_found;
        if (i_clr) begin
            n_found = 1'b0;
        end else if (i_en && match) begin
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    assign o_found = r_found;

endmodule

FILE: sv/uee_merge.sv
// merge stage: drops edges already in the table and in-triangle repeats, and marks the last new edge
module uee_merge import uee_pkg::*; #(
    parameter int VW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic [LANES-1:0][VW-1:0] i_from,
    input  logic [LANES-1:0][VW-1:0] i_to,
    input  logic [LANES-1:0]         i_found,
    output t_merge                   o_sel
);

    t_merge r_sel;
    t_merge n_sel;

    always_comb begin
        logic [LANES-1:0] dup;
        logic [LANES-1:0] later;
        dup   = '0;
        later = '0;
        for (int j = 0; j < LANES; j++) begin
            for (int i = 0; i < j; i++) begin
                if (((i_from[i] == i_from[j]) && (i_to[i] == i_to[j])) ||
                    ((i_from[i] == i_to[j]) && (i_to[i] == i_from[j]))) begin
                    dup[j] = 1'b1;
                end
            end
        end
        n_sel.is_new = ~i_found & ~dup;
        for (int j = 0; j < LANES; j++) begin
            for (int i = j + 1; i < LANES; i++) begin
                if (n_sel.is_new[i]) begin
                    later[j] = 1'b1;
                end
            end
        end
        n_sel.is_last = n_sel.is_new & ~later;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sel <= n_sel;
        end
    end

    assign o_sel = r_sel;

endmodule

FILE: sv/unique_edge_extractor.sv
// top level: unique edge table with three compare lanes and result sequencer
//
// A triangle is taken when start is high and busy is low. Its edges are
// checked in parallel, one lane each, while the stored table is read out one
// entry per clock through the single memory read port; the scan covers the
// edges stored before the triangle, none when first_triangle is set. New
// edges come out on o_strobe, at most one per cycle, in edge order, after
// the scan by way of the merge and emit states; the receiver cannot stall,
// so each result is valid for one cycle only. The table is not cleared
// after reset and needs no clearing pass: only entries below the count are
// ever read.
module unique_edge_extractor import uee_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int INDEX_BITS  = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int VW = (INDEX_BITS < VERTEX_W) ? INDEX_BITS : VERTEX_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [1:0] LAST_LANE = 2'(LANES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_MERGE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [LANES-1:0][VW-1:0] r_vert;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_addr, n_addr;
    logic [1:0]               r_lane, n_lane;
    logic                     r_rd_vld;
    logic [2*VW-1:0]          r_rd_data;
    logic                     r_strobe, n_strobe;
    t_result                  r_result, n_result;
    logic [2*VW-1:0]          r_mem [TABLE_DEPTH];

    logic                     rd_en;
    logic                     wr_en;
    logic                     clr;
    logic [LANES-1:0][VW-1:0] e_from;
    logic [LANES-1:0][VW-1:0] e_to;
    logic [LANES-1:0]         found;
    t_merge                   sel;

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        assign e_from[j] = r_vert[j];
        assign e_to[j]   = r_vert[(j + 1) % LANES];

        uee_lane #(.VW(VW)) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (clr),
            .i_en    (r_rd_vld),
            .i_from  (e_from[j]),
            .i_to    (e_to[j]),
            .i_entry (r_rd_data),
            .o_found (found[j])
        );
    end

    uee_merge #(.VW(VW)) u_merge (
        .i_clk   (i_clk),
        .i_load  (r_state == S_MERGE),
        .i_from  (e_from),
        .i_to    (e_to),
        .i_found (found),
        .o_sel   (sel)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_addr   = r_addr;
        n_lane   = r_lane;
        n_strobe = 1'b0;
        n_result = r_result;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        clr      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                    clr     = 1'b1;
                    if (i_item.first_triangle) begin
                        n_count = '0;
                    end
                end
            end
            S_SCAN: begin
                rd_en = (r_addr < r_count);
                if (rd_en) begin
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                n_state = S_EMIT;
                n_lane  = '0;
            end
            S_EMIT: begin
                if (sel.is_new[r_lane]) begin
                    n_strobe           = 1'b1;
                    n_result.edge_from = VERTEX_W'(e_from[r_lane]);
                    n_result.edge_to   = VERTEX_W'(e_to[r_lane]);
                    if (r_count < DEPTH_C) begin
                        wr_en                = 1'b1;
                        n_count              = r_count + 1'b1;
                        n_result.edge_number = EDGE_NUM_W'(32'(r_count));
                        n_result.dropped     = 1'b0;
                    end else begin
                        n_result.edge_number = '0;
                        n_result.dropped     = 1'b1;
                    end
                    n_result.total_edges      = TOTAL_W'(32'(n_count));
                    n_result.last_of_triangle = sel.is_last[r_lane];
                end
                if (r_lane == LAST_LANE) begin
                    n_state = S_IDLE;
                end else begin
                    n_lane = r_lane + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= rd_en;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_lane   <= n_lane;
        r_result <= n_result;
        if (clr) begin
            r_vert[0] <= i_item.vertex_a[VW-1:0];
            r_vert[1] <= i_item.vertex_b[VW-1:0];
            r_vert[2] <= i_item.vertex_c[VW-1:0];
        end
    end

    // edge table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= {e_from[r_lane], e_to[r_lane]};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: sv/uee_checker.sv
// port-level checks for the unique edge extractor and their binding
module uee_checker import uee_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    localparam logic [TOTAL_W-1:0] FULL_TOTAL = TOTAL_W'(TABLE_DEPTH);

    // an accepted transaction keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // results only follow busy cycles
    a_strobe_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    // a dropped edge reports a full table and position zero
    a_dropped_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.dropped |->
            (o_result.edge_number == '0) && (o_result.total_edges == FULL_TOTAL))
        else $error("dropped result with wrong number or total");

    // a stored edge's total is its position plus one (checked for tables of up to 1024 entries)
    a_stored_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.dropped |->
            (TABLE_DEPTH > 1024) ||
            (o_result.total_edges == TOTAL_W'(o_result.edge_number) + 1'b1))
        else $error("total does not follow edge number");

endmodule

bind unique_edge_extractor uee_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_uee_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
